### rtl/mppt_pkg.sv
// ----------------------------------------------------------------------------
// mppt_pkg
// Shared widths, register indexes, reset values and the command/status
// bundles between the sweep controller FSM and its datapath.
// ----------------------------------------------------------------------------
package mppt_pkg;

  localparam int CUR_W   = 15;   // charge current, mA
  localparam int TIME_W  = 32;   // system time, ms
  localparam int LIM_W   = 16;   // voltage limit, mV
  localparam int STEP_W  = 12;   // limit step, mV
  localparam int BIN_W   = 6;    // bin index on the result port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // bin voltage: min + bin * step, before saturation
  localparam int FIN_W = BIN_W + STEP_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

  // register reset values
  localparam logic [LIM_W-1:0]  RST_MIN_LIMIT = 16'd3900;
  localparam logic [STEP_W-1:0] RST_STEP      = 12'd100;
  localparam logic [TIME_W-1:0] RST_INTERVAL  = 32'd60000;
  localparam logic [CUR_W-1:0]  RST_THRESHOLD = 15'd100;

  // operation codes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [LIM_W-1:0] LIM_MAX = '1;

  typedef struct packed {
    logic capture;     // take the input item
    logic restart;     // clear bins, start scan at minimum
    logic scan_step;   // store sample, advance bin and limit
    logic walk_start;  // clear argmax state
    logic hold_rd;     // read selected bin for hold check
    logic hold_eval;   // evaluate rescan trigger
    logic walk_rd;     // read next bin for argmax
    logic finish;      // apply best bin, enter hold
    logic load_out;    // load result register
  } mppt_cmd_t;

  typedef struct packed {
    logic enable;
    logic op;
    logic holding;
    logic scan_end;    // sample goes into the last bin
    logic walk_last;   // last bin read issued this cycle
    logic out_free;    // result register can take a new item
  } mppt_sts_t;

endpackage

### rtl/mppt_sweep_controller.sv
// ----------------------------------------------------------------------------
// mppt_sweep_controller
// Sweep-and-hold maximum power point tracker for a charger input voltage
// limit. One result item per input item. Items are handled one at a time:
// a plain sample, restart or disabled item goes from decode straight to the
// result hand-off, a hold-check item passes a hold evaluation state first,
// and the sample that fills the last bin adds the argmax walk, which reads
// the bin memory one entry a cycle through its single read port, then waits
// for the last compare and applies the best bin. Output stalls lengthen each
// case while a result waits for the register. A new item is taken while the
// previous result still waits in the output register. Bin currents live in a
// memory with one valid bit per bin; reset and restart clear the valid bits
// at once, so no clearing pass is needed. Configuration is to be written
// through cfg_we/cfg_index/cfg_wdata only while the block is idle; the block
// itself does not enforce this. Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module mppt_sweep_controller import mppt_pkg::*; #(
  parameter int NUM_BINS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [CUR_W-1:0]     in_charge_current,
  input  logic [TIME_W-1:0]    in_now_ms,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LIM_W-1:0]     out_limit_mv,
  output logic                 out_limit_write,
  output logic                 out_scan_running,
  output logic [BIN_W-1:0]     out_selected_bin
);

  // command and status between sequencer and datapath
  mppt_cmd_t cmd;
  mppt_sts_t sts;

  // sequencer: decode, hold check, bin walk, result hand-off
  mppt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: registers, bin memory, argmax, result register
  mppt_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_operation      (in_operation),
    .in_charge_current (in_charge_current),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_limit_mv      (out_limit_mv),
    .out_limit_write   (out_limit_write),
    .out_scan_running  (out_scan_running),
    .out_selected_bin  (out_selected_bin),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

### rtl/mppt_ctrl.sv
// ----------------------------------------------------------------------------
// mppt_ctrl
// Sequencer for one item at a time: decode, hold check, bin walk for the
// argmax, and hand-off to the result register.
// ----------------------------------------------------------------------------
module mppt_ctrl import mppt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mppt_sts_t sts,
  output mppt_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_HOLD   = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_WEND   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE) || !rst_n;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.enable) begin
          state_nxt = S_OUT;
        end else if (sts.op == OP_RESTART) begin
          cmd.restart = 1'b1;
          state_nxt   = S_OUT;
        end else if (sts.holding) begin
          cmd.hold_rd = 1'b1;
          state_nxt   = S_HOLD;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_end) begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_WALK;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_HOLD: begin
        cmd.hold_eval = 1'b1;
        state_nxt     = S_OUT;
      end
      S_WALK: begin
        cmd.walk_rd = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_WEND;
        end
      end
      S_WEND: begin
        // last compare lands this cycle
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |=> (state_r == S_WALK || state_r == S_WEND))
    else $error("bin walk left by an unexpected path");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECIDE))
    else $error("accepted item not decoded");

endmodule

### rtl/mppt_dp.sv
// ----------------------------------------------------------------------------
// mppt_dp
// Datapath: configuration registers, tracker state, bin current memory with
// valid bits, argmax walk and the result register.
// ----------------------------------------------------------------------------
module mppt_dp import mppt_pkg::*; #(
  parameter int NUM_BINS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_operation,
  input  logic [CUR_W-1:0]     in_charge_current,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LIM_W-1:0]     out_limit_mv,
  output logic                 out_limit_write,
  output logic                 out_scan_running,
  output logic [BIN_W-1:0]     out_selected_bin,
  input  mppt_cmd_t            cmd,
  output mppt_sts_t            sts
);

  localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // configuration
  logic              en_r;
  logic [LIM_W-1:0]  min_r;
  logic [STEP_W-1:0] step_r;
  logic [TIME_W-1:0] intv_r;
  logic [CUR_W-1:0]  thr_r;

  // captured item
  logic              op_r;
  logic [CUR_W-1:0]  cur_r;
  logic [TIME_W-1:0] now_r;

  // tracker state
  logic [BIN_W-1:0]  bin_idx_r, bin_idx_nxt;
  logic [LIM_W-1:0]  lim_r, lim_nxt;
  logic              holding_r, holding_nxt;
  logic [TIME_W-1:0] end_time_r, end_time_nxt;
  logic              wr_flag_r;

  // bin store
  logic [CUR_W-1:0]    bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid_r;
  logic [CUR_W-1:0]    rd_q_r;
  logic                rd_v_r;
  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    widx;

  // argmax walk
  logic [IDX_W-1:0] walk_cnt_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [CUR_W-1:0] best_r;
  logic [IDX_W-1:0] besti_r;

  logic                   out_valid_r;
  logic [LIM_W-1:0]       out_lim_r;
  logic                   out_wr_r;
  logic                   out_run_r;
  logic [BIN_W-1:0]       out_bin_r;

  logic [CUR_W-1:0]       rd_val;
  logic [CUR_W-1:0]       diff;
  logic [TIME_W-1:0]      elapsed;
  logic                   trig;
  logic [LIM_W:0]         step_sum;
  logic [LIM_W-1:0]       step_lim;
  logic [BIN_W+STEP_W-1:0] prod;
  logic [FIN_W-1:0]       fin_sum;
  logic [LIM_W-1:0]       fin_lim;
  logic [BIN_W:0]         idx_inc;

  // --- configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      min_r  <= RST_MIN_LIMIT;
      step_r <= RST_STEP;
      intv_r <= RST_INTERVAL;
      thr_r  <= RST_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:    en_r   <= cfg_wdata[0];
        REG_MIN_LIMIT: min_r  <= cfg_wdata[LIM_W-1:0];
        REG_STEP:      step_r <= cfg_wdata[STEP_W-1:0];
        REG_INTERVAL:  intv_r <= cfg_wdata[TIME_W-1:0];
        REG_THRESHOLD: thr_r  <= cfg_wdata[CUR_W-1:0];
        default: ;
      endcase
    end
  end

  // --- item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      cur_r <= in_charge_current;
      now_r <= in_now_ms;
    end
  end

  // --- arithmetic
  assign rd_val   = rd_v_r ? rd_q_r : '0;
  assign diff     = (cur_r >= rd_val) ? (cur_r - rd_val) : (rd_val - cur_r);
  assign elapsed  = now_r - end_time_r;
  assign trig     = (elapsed > intv_r) || (diff >= thr_r);

  assign step_sum = {1'b0, lim_r} + (LIM_W+1)'(step_r);
  assign step_lim = (lim_r == '0) ? min_r :
                    (step_sum[LIM_W] ? LIM_MAX : step_sum[LIM_W-1:0]);

  assign prod    = (BIN_W+STEP_W)'(BIN_W'(besti_r)) * (BIN_W+STEP_W)'(step_r);
  assign fin_sum = FIN_W'(prod) + FIN_W'(min_r);
  assign fin_lim = (fin_sum[FIN_W-1:LIM_W] != '0) ? LIM_MAX : fin_sum[LIM_W-1:0];

  assign idx_inc = {1'b0, bin_idx_r} + (BIN_W+1)'(1);

  // --- tracker state
  always_comb begin
    bin_idx_nxt  = bin_idx_r;
    lim_nxt      = lim_r;
    holding_nxt  = holding_r;
    end_time_nxt = end_time_r;
    if (cmd.restart) begin
      bin_idx_nxt  = '0;
      lim_nxt      = min_r;
      end_time_nxt = now_r;
      holding_nxt  = 1'b0;
    end
    if (cmd.scan_step) begin
      // park at bin 0 during the walk; finish loads the chosen bin
      bin_idx_nxt = sts.scan_end ? '0 : idx_inc[BIN_W-1:0];
      lim_nxt     = step_lim;
    end
    if (cmd.hold_eval && trig) begin
      holding_nxt = 1'b0;
      bin_idx_nxt = '0;
      lim_nxt     = min_r;
    end
    if (cmd.finish) begin
      holding_nxt  = 1'b1;
      end_time_nxt = now_r;
      bin_idx_nxt  = BIN_W'(besti_r);
      lim_nxt      = fin_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_idx_r  <= '0;
      lim_r      <= '0;
      holding_r  <= 1'b0;
      end_time_r <= '0;
      wr_flag_r  <= 1'b0;
    end else begin
      bin_idx_r  <= bin_idx_nxt;
      lim_r      <= lim_nxt;
      holding_r  <= holding_nxt;
      end_time_r <= end_time_nxt;
      if (cmd.capture) begin
        wr_flag_r <= 1'b0;
      end else if (cmd.restart || cmd.scan_step) begin
        wr_flag_r <= 1'b1;
      end else if (cmd.hold_eval) begin
        wr_flag_r <= trig;
      end
    end
  end

  // --- bin memory, one write and one read port
  assign widx  = bin_idx_r[IDX_W-1:0];
  assign raddr = cmd.hold_rd ? bin_idx_r[IDX_W-1:0] : walk_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      bin_mem[widx] <= cur_r;
    end
    rd_q_r <= bin_mem[raddr];
    rd_v_r <= valid_r[raddr];
  end

  // an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      valid_r <= '0;
    end else if (cmd.scan_step) begin
      valid_r[widx] <= 1'b1;
    end
  end

  // --- argmax walk: read one bin a cycle, compare it in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.walk_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      walk_cnt_r <= '0;
      best_r     <= '0;
      besti_r    <= '0;
    end else begin
      if (cmd.walk_rd) begin
        walk_cnt_r <= walk_cnt_r + IDX_W'(1);
        cmp_idx_r  <= walk_cnt_r;
      end
      // strict compare keeps the first bin on ties
      if (cmp_vld_r && (rd_val > best_r)) begin
        best_r  <= rd_val;
        besti_r <= cmp_idx_r;
      end
    end
  end

  // --- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_lim_r <= en_r ? lim_r : '0;
      out_wr_r  <= wr_flag_r;
      out_run_r <= !holding_r;
      out_bin_r <= bin_idx_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_limit_mv     = out_lim_r;
  assign out_limit_write  = out_wr_r;
  assign out_scan_running = out_run_r;
  assign out_selected_bin = out_bin_r;

  // --- status to the sequencer
  assign sts.enable    = en_r;
  assign sts.op        = op_r;
  assign sts.holding   = holding_r;
  assign sts.scan_end  = (idx_inc >= (BIN_W+1)'(NUM_BINS));
  assign sts.walk_last = (walk_cnt_r == IDX_W'(NUM_BINS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> ({1'b0, bin_idx_r} < (BIN_W+1)'(NUM_BINS)))
    else $error("bin index out of range");

  a_hold_writes: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(holding_r) |-> wr_flag_r)
    else $error("entering hold without a limit write");

endmodule
